// ----- src/mdp_pkg.sv -----
package mdp_pkg;

	// Field phase of the byte parser.
	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_LEN    = 4'd1,
		PH_LAYOUT = 4'd2,
		PH_CELL   = 4'd3,
		PH_PRES   = 4'd4,
		PH_COUNT  = 4'd5,
		PH_ELEM   = 4'd6,
		PH_LINK   = 4'd7,
		PH_IDS    = 4'd8
	} phase_t;

	// Kind of a result transaction.
	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_ELEM   = 2'd1,
		KIND_CELL   = 2'd2,
		KIND_TRUNC  = 2'd3
	} kind_t;

	// Cell linkage codes that carry id bytes.
	localparam logic [7:0] LINK_BOUQUET = 8'h01;
	localparam logic [7:0] LINK_TS_A    = 8'h02;
	localparam logic [7:0] LINK_TS_B    = 8'h03;
	localparam logic [7:0] LINK_EVENT   = 8'h04;

	// Number of id bytes that follow each linkage code.
	localparam logic [3:0] IDS_BOUQUET = 4'd2;
	localparam logic [3:0] IDS_TS      = 4'd6;
	localparam logic [3:0] IDS_EVENT   = 4'd8;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_descriptor;
	} mdp_in_t;

	typedef struct packed {
		logic [1:0]  record_kind;
		logic [6:0]  mosaic_layout;
		logic [5:0]  cell_id;
		logic [2:0]  presentation_info;
		logic [7:0]  linkage_code;
		logic [7:0]  element_count;
		logic [15:0] bouquet_id;
		logic [15:0] network_id;
		logic [15:0] stream_id;
		logic [15:0] service_number;
		logic [15:0] event_number;
		logic        descriptor_end;
	} mdp_out_t;

endpackage

// ----- src/mdp_stream_if.sv -----
// Valid/ready channel with a typed payload.
interface mdp_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/mosaic_descriptor_parser_top.sv -----
// Channel  Modport  Payload    Moves per transaction
// desc     sink     mdp_in_t   one descriptor byte with its start mark
// rec      source   mdp_out_t  one parsed result (header, element, cell, truncation)
//
// Each byte is parsed in the cycle it is accepted; its result, if any, appears
// in the output register in the next cycle. One byte per cycle is sustained
// while no result is stalled; the single output register holds a stalled result.
// Reset clears the parser to idle and empties the output register.
// desc.ready drops only while a result waits and rec.ready is low.
module mosaic_descriptor_parser_top (
	input logic          clk,
	input logic          arst_n,
	mdp_stream_if.sink   desc,
	mdp_stream_if.source rec
);

	logic              take;
	logic              res_valid;
	mdp_pkg::mdp_out_t res;
	logic              rec_valid_q;
	mdp_pkg::mdp_out_t rec_q;

	assign desc.ready = !rec_valid_q || rec.ready;
	assign take       = desc.valid && desc.ready;

	mdp_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item      (desc.data),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (take) begin
			rec_valid_q <= res_valid;
		end else if (rec.ready) begin
			rec_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			rec_q <= res;
		end
	end

	assign rec.valid = rec_valid_q;
	assign rec.data  = rec_q;

endmodule

// ----- src/mdp_step.sv -----
// Parser state and the per-byte update. The result of an accepted byte is
// presented combinationally for the output register of the top level.
module mdp_step (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  mdp_pkg::mdp_in_t item,
	output logic             res_valid,
	output mdp_pkg::mdp_out_t res
);

	mdp_pkg::phase_t phase_q, phase_n;
	logic [7:0]  bytes_q, bytes_n;
	logic [6:0]  layout_q, layout_n;
	logic [5:0]  cell_q, cell_n;
	logic [2:0]  pres_q, pres_n;
	logic [7:0]  count_q, count_n;
	logic [7:0]  elem_q, elem_n;
	logic [7:0]  link_q, link_n;
	logic [3:0]  lbl_q, lbl_n;
	logic [63:0] shift_q, shift_n;

	logic [7:0]  b;
	logic [7:0]  bl;
	logic        last;
	logic [6:0]  lay;
	logic [3:0]  need;
	logic [3:0]  lbl_dec;
	logic [63:0] shift_in;
	logic        do_rec;
	logic        do_trunc;
	logic [7:0]  rec_code;
	logic [63:0] rec_shift;

	assign b        = item.data_byte;
	assign bl       = bytes_q - 8'd1;
	assign last     = (bl == 8'd0);
	assign lay      = {b[7], b[6:4], b[2:0]};
	assign lbl_dec  = lbl_q - 4'd1;
	assign shift_in = {shift_q[55:0], b};

	// Id bytes that follow a linkage code.
	always_comb begin
		case (b)
			mdp_pkg::LINK_BOUQUET: need = mdp_pkg::IDS_BOUQUET;
			mdp_pkg::LINK_TS_A,
			mdp_pkg::LINK_TS_B:    need = mdp_pkg::IDS_TS;
			mdp_pkg::LINK_EVENT:   need = mdp_pkg::IDS_EVENT;
			default:               need = 4'd0;
		endcase
	end

	// Next state and result for one accepted byte.
	always_comb begin
		phase_n   = phase_q;
		bytes_n   = bytes_q;
		layout_n  = layout_q;
		cell_n    = cell_q;
		pres_n    = pres_q;
		count_n   = count_q;
		elem_n    = elem_q;
		link_n    = link_q;
		lbl_n     = lbl_q;
		shift_n   = shift_q;
		res_valid = 1'b0;
		res       = '0;
		res.mosaic_layout = layout_q;
		do_rec    = 1'b0;
		do_trunc  = 1'b0;
		rec_code  = link_q;
		rec_shift = shift_q;

		if (take) begin
			if (item.start_of_descriptor) begin
				phase_n  = mdp_pkg::PH_LEN;
				bytes_n  = 8'd0;
				layout_n = 7'd0;
				cell_n   = 6'd0;
				pres_n   = 3'd0;
				count_n  = 8'd0;
				elem_n   = 8'd0;
				link_n   = 8'd0;
				lbl_n    = 4'd0;
				shift_n  = 64'd0;
			end else begin
				case (phase_q)
					mdp_pkg::PH_LEN: begin
						bytes_n = b;
						if (b == 8'd0) begin
							do_trunc = 1'b1;
						end else begin
							phase_n = mdp_pkg::PH_LAYOUT;
						end
					end
					mdp_pkg::PH_LAYOUT: begin
						bytes_n  = bl;
						layout_n = lay;
						res_valid = 1'b1;
						res.record_kind    = mdp_pkg::KIND_HEADER;
						res.mosaic_layout  = lay;
						res.descriptor_end = last;
						phase_n = last ? mdp_pkg::PH_IDLE : mdp_pkg::PH_CELL;
					end
					mdp_pkg::PH_CELL: begin
						bytes_n = bl;
						cell_n  = b[7:2];
						if (last) do_trunc = 1'b1;
						else phase_n = mdp_pkg::PH_PRES;
					end
					mdp_pkg::PH_PRES: begin
						bytes_n = bl;
						pres_n  = b[2:0];
						if (last) do_trunc = 1'b1;
						else phase_n = mdp_pkg::PH_COUNT;
					end
					mdp_pkg::PH_COUNT: begin
						bytes_n = bl;
						count_n = b;
						elem_n  = b;
						if (last) do_trunc = 1'b1;
						else phase_n = (b != 8'd0) ? mdp_pkg::PH_ELEM : mdp_pkg::PH_LINK;
					end
					mdp_pkg::PH_ELEM: begin
						bytes_n = bl;
						if (last) begin
							do_trunc = 1'b1;
						end else begin
							elem_n = elem_q - 8'd1;
							if (elem_q == 8'd1) phase_n = mdp_pkg::PH_LINK;
							res_valid = 1'b1;
							res.record_kind = mdp_pkg::KIND_ELEM;
							res.cell_id     = b[5:0];
						end
					end
					mdp_pkg::PH_LINK: begin
						bytes_n  = bl;
						link_n   = b;
						rec_code = b;
						if (need == 4'd0) begin
							do_rec = 1'b1;
						end else if (last) begin
							do_trunc = 1'b1;
						end else begin
							lbl_n   = need;
							shift_n = 64'd0;
							phase_n = mdp_pkg::PH_IDS;
						end
					end
					mdp_pkg::PH_IDS: begin
						bytes_n   = bl;
						shift_n   = shift_in;
						lbl_n     = lbl_dec;
						rec_shift = shift_in;
						if (lbl_dec == 4'd0) do_rec = 1'b1;
						else if (last) do_trunc = 1'b1;
					end
					default: begin
						// Idle: bytes without a start mark are dropped.
					end
				endcase

				// A completed logical cell.
				if (do_rec) begin
					res_valid = 1'b1;
					res.record_kind       = mdp_pkg::KIND_CELL;
					res.cell_id           = cell_q;
					res.presentation_info = pres_q;
					res.linkage_code      = rec_code;
					res.element_count     = count_q;
					res.descriptor_end    = last;
					if (rec_code == mdp_pkg::LINK_BOUQUET) begin
						res.bouquet_id = rec_shift[15:0];
					end else if (rec_code == mdp_pkg::LINK_TS_A ||
							rec_code == mdp_pkg::LINK_TS_B) begin
						res.network_id     = rec_shift[47:32];
						res.stream_id      = rec_shift[31:16];
						res.service_number = rec_shift[15:0];
					end else if (rec_code == mdp_pkg::LINK_EVENT) begin
						res.network_id     = rec_shift[63:48];
						res.stream_id      = rec_shift[47:32];
						res.service_number = rec_shift[31:16];
						res.event_number   = rec_shift[15:0];
					end
					cell_n  = 6'd0;
					pres_n  = 3'd0;
					count_n = 8'd0;
					elem_n  = 8'd0;
					link_n  = 8'd0;
					lbl_n   = 4'd0;
					shift_n = 64'd0;
					phase_n = last ? mdp_pkg::PH_IDLE : mdp_pkg::PH_CELL;
				end

				// Descriptor ended inside a cell, or had zero length.
				if (do_trunc) begin
					res_valid = 1'b1;
					res.record_kind    = mdp_pkg::KIND_TRUNC;
					res.descriptor_end = 1'b1;
					phase_n = mdp_pkg::PH_IDLE;
				end
			end
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= mdp_pkg::PH_IDLE;
			bytes_q  <= 8'd0;
			layout_q <= 7'd0;
			cell_q   <= 6'd0;
			pres_q   <= 3'd0;
			count_q  <= 8'd0;
			elem_q   <= 8'd0;
			link_q   <= 8'd0;
			lbl_q    <= 4'd0;
			shift_q  <= 64'd0;
		end else begin
			phase_q  <= phase_n;
			bytes_q  <= bytes_n;
			layout_q <= layout_n;
			cell_q   <= cell_n;
			pres_q   <= pres_n;
			count_q  <= count_n;
			elem_q   <= elem_n;
			link_q   <= link_n;
			lbl_q    <= lbl_n;
			shift_q  <= shift_n;
		end
	end

endmodule

// ----- src/mdp_checker.sv -----
// Port-level checks for the mosaic descriptor parser.
module mdp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              desc_valid,
	input logic              desc_ready,
	input mdp_pkg::mdp_in_t  desc_data,
	input logic              rec_valid,
	input logic              rec_ready,
	input mdp_pkg::mdp_out_t rec_data
);

	// A stalled result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && !rec_ready |=> rec_valid)
		else $error("result dropped while stalled");

	// With no result waiting, the input side is always open.
	assert property (@(posedge clk) disable iff (!arst_n)
		!rec_valid |-> desc_ready)
		else $error("input blocked with empty output");

	// A start byte produces no result.
	assert property (@(posedge clk) disable iff (!arst_n)
		desc_valid && desc_ready && desc_data.start_of_descriptor &&
		!(rec_valid && !rec_ready) |=> !rec_valid)
		else $error("result after start byte");

	// Only cell records carry linkage ids, and truncations always end the descriptor.
	assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_data.record_kind != mdp_pkg::KIND_CELL |->
		rec_data.bouquet_id == 16'd0 && rec_data.network_id == 16'd0 &&
		rec_data.stream_id == 16'd0 && rec_data.service_number == 16'd0 &&
		rec_data.event_number == 16'd0 &&
		(rec_data.record_kind != mdp_pkg::KIND_TRUNC || rec_data.descriptor_end))
		else $error("bad fields in non-cell result");

endmodule

bind mosaic_descriptor_parser_top mdp_checker u_mdp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.desc_valid (desc.valid),
	.desc_ready (desc.ready),
	.desc_data  (desc.data),
	.rec_valid  (rec.valid),
	.rec_ready  (rec.ready),
	.rec_data   (rec.data)
);
